/* rtl/vn_pkg.sv */
package vn_pkg;

	localparam int unsigned MAX_COMPONENTS = 4;
	localparam int unsigned SAMPLE_WIDTH   = 16;
	localparam int unsigned COUNT_WIDTH    = 3;
	localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 3'd3;

endpackage

/* rtl/vn_lane_stage.sv */
module vn_lane_stage import vn_pkg::*; #(
	parameter int unsigned W = SAMPLE_WIDTH,
	parameter int unsigned K = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [W-1:0]     n_in,
	input  logic [4*W+3:0]   v2s_in,
	input  logic [4*W+3:0]   vs_in,
	input  logic [4*W+3:0]   s_in,
	input  logic [4*W+3:0]   r_in,
	input  logic             neg_in,
	output logic [W-1:0]     n_out,
	output logic [4*W+3:0]   v2s_out,
	output logic [4*W+3:0]   vs_out,
	output logic [4*W+3:0]   s_out,
	output logic [4*W+3:0]   r_out,
	output logic             neg_out
);
	localparam int unsigned AW = 4*W+4;

	logic [AW-1:0] v2s_try;
	logic [AW-1:0] vs_try;
	logic [AW-1:0] test;
	logic          take;

	// try setting bit K of n: v = 2n grows by 2^(K+1)
	always_comb begin
		v2s_try = v2s_in + (vs_in << (K+2)) + (s_in << (2*K+2));
		vs_try  = vs_in + (s_in << (K+1));
		test    = v2s_try - (vs_try << 1) + s_in;
		take    = !n_in[W-1] && (test <= r_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_out   <= take ? (n_in | (W'(1) << K)) : n_in;
			v2s_out <= take ? v2s_try : v2s_in;
			vs_out  <= take ? vs_try : vs_in;
			s_out   <= s_in;
			r_out   <= r_in;
			neg_out <= neg_in;
		end
	end
endmodule

/* rtl/vn_lane.sv */
module vn_lane import vn_pkg::*; #(
	parameter int unsigned W = SAMPLE_WIDTH
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   mag,
	input  logic           neg,
	input  logic [4*W+3:0] sum,
	output logic [W-1:0]   n,
	output logic           neg_out
);
	localparam int unsigned AW = 4*W+4;

	logic [W-1:0]  n_c   [0:W];
	logic [AW-1:0] v2s_c [0:W];
	logic [AW-1:0] vs_c  [0:W];
	logic [AW-1:0] s_c   [0:W];
	logic [AW-1:0] r_c   [0:W];
	logic          neg_c [0:W];

	// search start: n = 0, target mag^2 * 2^(2W)
	always_comb begin
		n_c[0]   = '0;
		v2s_c[0] = '0;
		vs_c[0]  = '0;
		s_c[0]   = sum;
		r_c[0]   = (AW'(mag) * AW'(mag)) << (2*W);
		neg_c[0] = neg;
	end

	// one result bit per stage, msb first
	for (genvar j = 0; j < W; j++) begin : g_step
		vn_lane_stage #(.W(W), .K(W-1-j)) u_stage (
			.clk     (clk),
			.en      (en),
			.n_in    (n_c[j]),
			.v2s_in  (v2s_c[j]),
			.vs_in   (vs_c[j]),
			.s_in    (s_c[j]),
			.r_in    (r_c[j]),
			.neg_in  (neg_c[j]),
			.n_out   (n_c[j+1]),
			.v2s_out (v2s_c[j+1]),
			.vs_out  (vs_c[j+1]),
			.s_out   (s_c[j+1]),
			.r_out   (r_c[j+1]),
			.neg_out (neg_c[j+1])
		);
	end

	assign n       = n_c[W];
	assign neg_out = neg_c[W];
endmodule

/* rtl/vector_normalize.sv */
// vector normalization by reciprocal square root, four lanes
// input channel: in_valid/in_ready with component_0..3, one pixel per request
// output channel: out_valid/out_ready with normalized_0..3 in Q1.(W-1)
// each output is component / sqrt(sum of squares of lanes in use),
// rounded to nearest, +1.0 saturated; zero vector or unused lane gives 0
// config: cfg_write_en/cfg_write_data set components_in_use, taken at once;
// write only while the pipeline is empty
// latency: out_valid rises SAMPLE_WIDTH + 1 cycles after the request is taken
// (input stage, one search stage per result bit in every lane, output register)
// throughput: one pixel per cycle; each lane resolves one quotient bit
// per stage with shift-and-add updates, so stages overlap fully
// while a result waits with out_ready low the whole pipeline holds and
// in_ready drops
// reset clears all valid flags and sets components_in_use to 3
module vector_normalize import vn_pkg::*; #(
	parameter int unsigned SAMPLE_W = SAMPLE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [COUNT_WIDTH-1:0] cfg_write_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [SAMPLE_W-1:0] component_0,
	input  logic signed [SAMPLE_W-1:0] component_1,
	input  logic signed [SAMPLE_W-1:0] component_2,
	input  logic signed [SAMPLE_W-1:0] component_3,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [SAMPLE_W-1:0] normalized_0,
	output logic signed [SAMPLE_W-1:0] normalized_1,
	output logic signed [SAMPLE_W-1:0] normalized_2,
	output logic signed [SAMPLE_W-1:0] normalized_3
);
	localparam int unsigned W  = SAMPLE_W;
	localparam int unsigned NC = MAX_COMPONENTS;
	localparam int unsigned AW = 4*W+4;
	localparam int unsigned D  = W + 1;
	localparam logic [W-1:0] HALF = W'(1) << (W-1);

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   en;
	logic [D-1:0]           vld_q;
	logic [NC-1:0]          keep_q [0:D-1];

	logic [W-1:0]  comp   [0:NC-1];
	logic [W-1:0]  mag_c  [0:NC-1];
	logic [NC-1:0] use_c;
	logic [AW-1:0] sum_c;

	logic [W-1:0]  mag_s1 [0:NC-1];
	logic          neg_s1 [0:NC-1];
	logic [AW-1:0] sum_s1;

	logic [W-1:0]  n_l   [0:NC-1];
	logic          neg_l [0:NC-1];
	logic [W-1:0]  res_q [0:NC-1];

	assign comp[0] = component_0;
	assign comp[1] = component_1;
	assign comp[2] = component_2;
	assign comp[3] = component_3;

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_write_en) begin
			count_q <= cfg_write_data;
		end
	end

	// magnitudes, lane mask and sum of squares
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NC; i++) begin
			mag_c[i] = comp[i][W-1] ? (W'(0) - comp[i]) : comp[i];
			use_c[i] = (32'(count_q) > i);
			if (use_c[i]) begin
				sum_c = sum_c + AW'(mag_c[i]) * AW'(mag_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				mag_s1[i] <= mag_c[i];
				neg_s1[i] <= comp[i][W-1];
			end
			sum_s1 <= sum_c;
			keep_q[0] <= (sum_c == '0) ? '0 : use_c;
			for (int j = 1; j < D; j++) begin
				keep_q[j] <= keep_q[j-1];
			end
		end
	end

	// valid flags down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[D-2:0], in_valid};
			out_valid <= vld_q[D-1];
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_lane
		vn_lane #(.W(W)) u_lane (
			.clk     (clk),
			.en      (en),
			.mag     (mag_s1[i]),
			.neg     (neg_s1[i]),
			.sum     (sum_s1),
			.n       (n_l[i]),
			.neg_out (neg_l[i])
		);
	end

	// merge: sign, saturation and lane masking
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				if (!keep_q[D-1][i]) begin
					res_q[i] <= '0;
				end else if (neg_l[i]) begin
					res_q[i] <= W'(0) - n_l[i];
				end else if (n_l[i] == HALF) begin
					res_q[i] <= HALF - W'(1);
				end else begin
					res_q[i] <= n_l[i];
				end
			end
		end
	end

	assign normalized_0 = res_q[0];
	assign normalized_1 = res_q[1];
	assign normalized_2 = res_q[2];
	assign normalized_3 = res_q[3];
endmodule

/* tb/vector_normalize_tb.sv */
module vector_normalize_tb;
	import vn_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [MAX_COMPONENTS-1:0][SAMPLE_WIDTH-1:0] pixel_t;

	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = SAMPLE_WIDTH + 12;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [COUNT_WIDTH-1:0] cfg_write_data;
	logic in_valid;
	logic in_ready;
	pixel_t in_pix;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_WIDTH-1:0] normalized_0, normalized_1, normalized_2, normalized_3;

	pixel_t pending_pixels[$];
	pixel_t expected_pixels[$];
	logic [COUNT_WIDTH-1:0] lane_count;
	int unsigned mismatches;
	int unsigned idle_cycles;
	logic request_taken;
	int unsigned in_gap, out_gap;
	bit in_steady, out_steady;

	vector_normalize DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.component_0(in_pix[0]),
		.component_1(in_pix[1]),
		.component_2(in_pix[2]),
		.component_3(in_pix[3]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.normalized_0(normalized_0),
		.normalized_1(normalized_1),
		.normalized_2(normalized_2),
		.normalized_3(normalized_3)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one lane: largest n with n - 1/2 <= mag * 2^15 / sqrt(sum), then sign and saturation
	function automatic logic [SAMPLE_WIDTH-1:0] unit_lane(logic [SAMPLE_WIDTH-1:0] raw,
			logic [79:0] sum_sq);
		logic [79:0] mag, rhs, lo, hi, mid, odd;
		mag = raw[SAMPLE_WIDTH-1] ? (80'd65536 - 80'(raw)) : 80'(raw);
		rhs = (mag * mag) << 32;
		lo = 0;
		hi = 80'd32768;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 2 * mid - 1;
			if (odd * odd * sum_sq <= rhs) lo = mid;
			else hi = mid - 1;
		end
		if (raw[SAMPLE_WIDTH-1]) return SAMPLE_WIDTH'(80'd65536 - lo);
		if (lo > 80'd32767) lo = 80'd32767;
		return SAMPLE_WIDTH'(lo);
	endfunction

	function automatic pixel_t normalize_pixel(pixel_t pix, logic [COUNT_WIDTH-1:0] count);
		pixel_t res;
		int unsigned used;
		logic [79:0] sum_sq, mag;
		used = (count > MAX_COMPONENTS) ? MAX_COMPONENTS : count;
		sum_sq = 0;
		res = '0;
		for (int i = 0; i < used; i++) begin
			mag = pix[i][SAMPLE_WIDTH-1] ? (80'd65536 - 80'(pix[i])) : 80'(pix[i]);
			sum_sq += mag * mag;
		end
		if (sum_sq != 0)
			for (int i = 0; i < used; i++) res[i] = unit_lane(pix[i], sum_sq);
		return res;
	endfunction

	task automatic report_mismatch(string what, int lane, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s lane %0d: got %0d expected %0d", what, lane,
			$signed(got), $signed(want));
		mismatches++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] random_sample();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 16)) - 8);
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			2: return 16'($signed($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// request driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_pix <= '0;
			in_gap <= 0;
			in_steady <= 1'b0;
		end else if (in_valid && !request_taken) begin
			in_valid <= 1'b1;
		end else if (!in_steady && in_gap != 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_pixels.size() != 0) begin
			in_valid <= 1'b1;
			in_pix <= pending_pixels.pop_front();
			in_gap <= pick_gap();
			if ($urandom_range(0, 63) == 0) in_steady <= ~in_steady;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result stall
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
			out_steady <= 1'b0;
		end else if (out_steady || out_gap == 0) begin
			out_ready <= 1'b1;
			out_gap <= pick_gap();
			if ($urandom_range(0, 63) == 0) out_steady <= ~out_steady;
		end else begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end
	end

	// monitor: predict on accepted request, check on accepted result, watchdog
	always @(posedge clk or negedge arst_n) begin
		pixel_t want, got;
		if (!arst_n) begin
			request_taken <= 1'b0;
			idle_cycles <= 0;
		end else begin
			request_taken <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_pixels.push_back(normalize_pixel(in_pix, lane_count));
			if (out_valid && out_ready) begin
				got = {normalized_3, normalized_2, normalized_1, normalized_0};
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected result", 0, got[0], 16'd0);
				end else begin
					want = expected_pixels.pop_front();
					for (int i = 0; i < MAX_COMPONENTS; i++)
						if (got[i] !== want[i]) report_mismatch("normalized", i, got[i], want[i]);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_pixels.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_lane_count(logic [COUNT_WIDTH-1:0] count);
		@(negedge clk);
		cfg_write_en = 1'b1;
		cfg_write_data = count;
		lane_count = count;
		@(negedge clk);
		cfg_write_en = 1'b0;
	endtask

	task automatic queue_random(int unsigned n);
		pixel_t pix;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < MAX_COMPONENTS; i++) pix[i] = random_sample();
			pending_pixels.push_back(pix);
		end
	endtask

	// stimulus
	initial begin
		logic [COUNT_WIDTH-1:0] counts[8];
		counts = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd7, 3'd5, 3'd3, 3'd4};
		mismatches = 0;
		lane_count = COUNT_RESET;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pixels at the reset lane count
		pending_pixels.push_back('0);
		pending_pixels.push_back({4{16'h8000}});
		pending_pixels.push_back({4{16'h7fff}});
		pending_pixels.push_back({16'h1234, 16'h0000, 16'h0000, 16'h0001});
		pending_pixels.push_back({16'h1234, 16'h0000, 16'h0000, 16'hffff});
		pending_pixels.push_back({16'h0000, 16'h0000, 16'h8000, 16'h0000});
		pending_pixels.push_back({16'h7fff, 16'h0000, 16'h0000, 16'h0000});
		pending_pixels.push_back({16'h0000, 16'h0003, 16'h0004, 16'h0000});
		pending_pixels.push_back({16'h0000, 16'h0001, 16'h0001, 16'h0001});
		pending_pixels.push_back({16'h5555, 16'haaaa, 16'h7fff, 16'h8000});
		pending_pixels.push_back({16'hffff, 16'h0001, 16'hffff, 16'h0001});
		pending_pixels.push_back({16'h0000, 16'h0001, 16'h7fff, 16'h8000});
		queue_random(180);
		wait_drained();

		foreach (counts[p]) begin
			write_lane_count(counts[p]);
			pending_pixels.push_back({4{16'h8000}});
			pending_pixels.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0005});
			pending_pixels.push_back({16'h0007, 16'h0000, 16'h0000, 16'h0000});
			queue_random(170);
			wait_drained();
		end

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
